[hdl/cff_pkg.sv]
// ----------------------------------------------------------------------------
// cff_pkg
// Shared widths, constants and stage records for the circle field evaluator.
// ----------------------------------------------------------------------------
package cff_pkg;

    localparam int COORD_W      = 16;
    localparam int ACC_W        = 18;
    localparam int FIELD_W      = 16;
    localparam int GRAD_W       = 16;
    localparam int RAD_W        = 15;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int FIELD_FRAC   = 15;
    localparam int EXTRA_BITS   = 8;
    localparam int DELTA_W      = COORD_W + 1;
    localparam int SQ_W         = 2 * DELTA_W;
    localparam int RADICAND_W   = SQ_W + 2 * EXTRA_BITS;
    localparam int ROOT_W       = RADICAND_W / 2;
    localparam int REM_W        = ROOT_W + 1;
    localparam int Q_W          = 15;
    localparam int DIV_W        = 41;
    localparam int GRAD_SHIFT   = 22;
    localparam int R1E_W        = RAD_W + EXTRA_BITS;

    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = Q_W;
    localparam int SQRT_FIRST   = 3;
    localparam int POST_STAGE   = SQRT_FIRST + SQRT_STAGES;
    localparam int DIV_FIRST    = POST_STAGE + 1;
    localparam int OUT_STAGE    = DIV_FIRST + DIV_STAGES;
    localparam int NSTAGE       = OUT_STAGE + 1;

    localparam logic [FIELD_W-1:0] FIELD_HALF = FIELD_W'(1 << (FIELD_FRAC - 1));
    localparam logic [FIELD_W-1:0] FIELD_ONE  = FIELD_W'(1 << FIELD_FRAC);
    localparam logic [Q_W-1:0]     GRAD_ONE   = Q_W'(16384);
    localparam logic [ACC_W:0]     BLEND_MAX  = (ACC_W+1)'((1 << ACC_W) - 1);

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_WIDTH = 2'd3;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic [DELTA_W-1:0] magx;
        logic [DELTA_W-1:0] magy;
        logic [ACC_W-1:0]   accum;
    } item_t;

    typedef struct packed {
        logic             sx;
        logic             sy;
        logic             ge;
        logic             ovf;
        logic             zero;
        logic [ACC_W-1:0] accum;
    } post_t;

    typedef struct packed {
        logic [RADICAND_W-1:0] rad;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
    } sqrt_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [Q_W-1:0]   q;
    } div_t;

endpackage

[hdl/circle_falloff_field_eval.sv]
// ----------------------------------------------------------------------------
// circle_falloff_field_eval
// Circle distance field with linear falloff, unit gradient and blend.
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   point_x, point_y, accum_in
// m_axis    out        m_axis_tvalid/m_axis_tready   field, blend, gradient, flags
// cfg       in         cfg_we                        cfg_addr, cfg_wdata
//
// One point per cycle unless the output stalls; 3 front stages, 25 square
// root cells, 1 setup stage, 15 divider cells, 1 output register.
// rst_n clears all stage valid bits and loads register reset values.
// Each stage advances when empty or when its successor advances, so
// bubbles collapse and input is taken while a result waits at the output.
// ----------------------------------------------------------------------------
module circle_falloff_field_eval
    import cff_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,  // point_x, point_y, accum_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,  // field_value, blended_field,
                                                 // grad_x, grad_y, at_center,
                                                 // blend_saturated
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic [RAD_W-1:0]          inner_radius_reg;
    logic [RAD_W-1:0]          falloff_width_reg;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    logic signed [DELTA_W-1:0] a_dx_reg;
    logic signed [DELTA_W-1:0] a_dy_reg;
    logic [ACC_W-1:0]          a_acc_reg;
    logic signed [SQ_W-1:0]    b_sqx_reg;
    logic signed [SQ_W-1:0]    b_sqy_reg;
    item_t                     b_item_reg;
    logic [SQ_W-1:0]           c_sq_reg;
    item_t                     c_item_reg;

    sqrt_t sq_in   [SQRT_STAGES];
    sqrt_t sq_out  [SQRT_STAGES];
    item_t sq_item_reg [SQRT_STAGES];

    div_t  gx_in [DIV_STAGES];
    div_t  gx_out[DIV_STAGES];
    div_t  gy_in [DIV_STAGES];
    div_t  gy_out[DIV_STAGES];
    div_t  fd_in [DIV_STAGES];
    div_t  fd_out[DIV_STAGES];
    post_t dv_post_reg [DIV_STAGES];

    div_t  d_gx_reg, d_gx_next;
    div_t  d_gy_reg, d_gy_next;
    div_t  d_fd_reg, d_fd_next;
    post_t d_post_reg, d_post_next;

    logic [ROOT_W-1:0] dq;
    logic [ROOT_W-1:0] r1e;
    logic [ROOT_W-1:0] diff;
    logic [RAD_W-1:0]  r2v;
    logic [DIV_W-1:0]  fnum;
    logic [DIV_W-1:0]  fden;

    logic [FIELD_W-1:0] o_field_reg, o_field_next;
    logic [ACC_W-1:0]   o_blend_reg, o_blend_next;
    logic [GRAD_W-1:0]  o_gx_reg, o_gx_next;
    logic [GRAD_W-1:0]  o_gy_reg, o_gy_next;
    logic               o_center_reg, o_center_next;
    logic               o_sat_reg, o_sat_next;
    logic [ACC_W:0]     sum;
    post_t              fin;
    logic [Q_W-1:0]     tq;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            inner_radius_reg  <= '0;
            falloff_width_reg <= RAD_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTER_X:      center_x_reg      <= cfg_wdata;
                REG_CENTER_Y:      center_y_reg      <= cfg_wdata;
                REG_INNER_RADIUS:  inner_radius_reg  <= cfg_wdata[RAD_W-1:0];
                REG_FALLOFF_WIDTH: falloff_width_reg <= cfg_wdata[RAD_W-1:0];
                default:           center_x_reg      <= center_x_reg;
            endcase
        end
    end

    // stage flow control
    always_comb
    begin
        en[OUT_STAGE] = !valid_reg[OUT_STAGE] || m_axis_tready;
        for (int k = OUT_STAGE - 1; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < NSTAGE; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign s_axis_tready = en[0];

    // offsets, squares, sum
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_dx_reg  <= DELTA_W'(signed'(s_axis_tdata[15:0])) - DELTA_W'(center_x_reg);
            a_dy_reg  <= DELTA_W'(signed'(s_axis_tdata[31:16])) - DELTA_W'(center_y_reg);
            a_acc_reg <= s_axis_tdata[49:32];
        end
        if (en[1])
        begin
            b_sqx_reg        <= SQ_W'(a_dx_reg) * SQ_W'(a_dx_reg);
            b_sqy_reg        <= SQ_W'(a_dy_reg) * SQ_W'(a_dy_reg);
            b_item_reg.sx    <= a_dx_reg[DELTA_W-1];
            b_item_reg.sy    <= a_dy_reg[DELTA_W-1];
            b_item_reg.magx  <= a_dx_reg[DELTA_W-1] ? DELTA_W'(-a_dx_reg) : a_dx_reg;
            b_item_reg.magy  <= a_dy_reg[DELTA_W-1] ? DELTA_W'(-a_dy_reg) : a_dy_reg;
            b_item_reg.accum <= a_acc_reg;
        end
        if (en[2])
        begin
            c_sq_reg   <= SQ_W'(b_sqx_reg) + SQ_W'(b_sqy_reg);
            c_item_reg <= b_item_reg;
        end
    end

    // square root chain
    generate
        for (genvar k = 0; k < SQRT_STAGES; k++)
        begin : g_sqrt
            if (k == 0)
            begin : g_first
                assign sq_in[k] = '{rad: {c_sq_reg, (2*EXTRA_BITS)'(0)},
                                    rem: '0, root: '0};
                always_ff @(posedge clk)
                begin
                    if (en[SQRT_FIRST+k])
                        sq_item_reg[k] <= c_item_reg;
                end
            end
            else
            begin : g_next
                assign sq_in[k] = sq_out[k-1];
                always_ff @(posedge clk)
                begin
                    if (en[SQRT_FIRST+k])
                        sq_item_reg[k] <= sq_item_reg[k-1];
                end
            end
            cff_sqrt_cell u_cell (
                .clk   (clk),
                .en    (en[SQRT_FIRST+k]),
                .d_in  (sq_in[k]),
                .d_out (sq_out[k])
            );
        end
    endgenerate

    // divider setup
    always_comb
    begin
        dq   = sq_out[SQRT_STAGES-1].root;
        r1e  = ROOT_W'({inner_radius_reg, EXTRA_BITS'(0)});
        r2v  = (falloff_width_reg == '0) ? RAD_W'(1) : falloff_width_reg;
        diff = (dq >= r1e) ? dq - r1e : r1e - dq;
        fnum = DIV_W'({diff, (FIELD_FRAC-1)'(0)}) + DIV_W'({r2v, (EXTRA_BITS-1)'(0)});
        fden = DIV_W'({r2v, EXTRA_BITS'(0)});

        d_fd_next.num = fnum;
        d_fd_next.den = fden << (Q_W - 1);
        d_fd_next.q   = '0;

        d_gx_next.num = DIV_W'({sq_item_reg[SQRT_STAGES-1].magx, GRAD_SHIFT'(0)})
                        + DIV_W'(dq >> 1);
        d_gx_next.den = DIV_W'(dq) << (Q_W - 1);
        d_gx_next.q   = '0;
        d_gy_next.num = DIV_W'({sq_item_reg[SQRT_STAGES-1].magy, GRAD_SHIFT'(0)})
                        + DIV_W'(dq >> 1);
        d_gy_next.den = DIV_W'(dq) << (Q_W - 1);
        d_gy_next.q   = '0;

        d_post_next.sx    = sq_item_reg[SQRT_STAGES-1].sx;
        d_post_next.sy    = sq_item_reg[SQRT_STAGES-1].sy;
        d_post_next.accum = sq_item_reg[SQRT_STAGES-1].accum;
        d_post_next.ge    = dq >= r1e;
        d_post_next.ovf   = fnum >= (fden << Q_W);
        d_post_next.zero  = dq == '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[POST_STAGE])
        begin
            d_gx_reg   <= d_gx_next;
            d_gy_reg   <= d_gy_next;
            d_fd_reg   <= d_fd_next;
            d_post_reg <= d_post_next;
        end
    end

    // divider chains
    generate
        for (genvar k = 0; k < DIV_STAGES; k++)
        begin : g_div
            if (k == 0)
            begin : g_first
                assign gx_in[k] = d_gx_reg;
                assign gy_in[k] = d_gy_reg;
                assign fd_in[k] = d_fd_reg;
                always_ff @(posedge clk)
                begin
                    if (en[DIV_FIRST+k])
                        dv_post_reg[k] <= d_post_reg;
                end
            end
            else
            begin : g_next
                assign gx_in[k] = gx_out[k-1];
                assign gy_in[k] = gy_out[k-1];
                assign fd_in[k] = fd_out[k-1];
                always_ff @(posedge clk)
                begin
                    if (en[DIV_FIRST+k])
                        dv_post_reg[k] <= dv_post_reg[k-1];
                end
            end
            cff_div_cell u_gx (
                .clk   (clk),
                .en    (en[DIV_FIRST+k]),
                .d_in  (gx_in[k]),
                .d_out (gx_out[k])
            );
            cff_div_cell u_gy (
                .clk   (clk),
                .en    (en[DIV_FIRST+k]),
                .d_in  (gy_in[k]),
                .d_out (gy_out[k])
            );
            cff_div_cell u_fd (
                .clk   (clk),
                .en    (en[DIV_FIRST+k]),
                .d_in  (fd_in[k]),
                .d_out (fd_out[k])
            );
        end
    endgenerate

    // field, blend, gradient
    function automatic logic [GRAD_W-1:0] grad_fix(input logic [Q_W-1:0] q, input logic neg);
        logic [GRAD_W-1:0] m;
        m = GRAD_W'((q > GRAD_ONE) ? GRAD_ONE : q);
        return neg ? GRAD_W'(-m) : m;
    endfunction

    always_comb
    begin
        fin = dv_post_reg[DIV_STAGES-1];
        tq  = fd_out[DIV_STAGES-1].q;
        if (fin.ge)
            o_field_next = (fin.ovf || FIELD_W'(tq) >= FIELD_HALF) ? '0
                           : FIELD_HALF - FIELD_W'(tq);
        else
            o_field_next = (fin.ovf || FIELD_W'(tq) > FIELD_HALF) ? FIELD_ONE
                           : FIELD_HALF + FIELD_W'(tq);
        sum          = (ACC_W+1)'(fin.accum) + (ACC_W+1)'(o_field_next);
        o_sat_next   = sum > BLEND_MAX;
        o_blend_next = o_sat_next ? BLEND_MAX[ACC_W-1:0] : sum[ACC_W-1:0];
        o_center_next = fin.zero;
        if (fin.zero)
        begin
            o_gx_next = '0;
            o_gy_next = '0;
        end
        else
        begin
            o_gx_next = grad_fix(gx_out[DIV_STAGES-1].q, fin.sx);
            o_gy_next = grad_fix(gy_out[DIV_STAGES-1].q, fin.sy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
        begin
            o_field_reg  <= o_field_next;
            o_blend_reg  <= o_blend_next;
            o_gx_reg     <= o_gx_next;
            o_gy_reg     <= o_gy_next;
            o_center_reg <= o_center_next;
            o_sat_reg    <= o_sat_next;
        end
    end

    assign m_axis_tvalid = valid_reg[OUT_STAGE];
    assign m_axis_tdata  = {4'b0, o_sat_reg, o_center_reg, o_gy_reg, o_gx_reg,
                            o_blend_reg, o_field_reg};

`ifndef NO_ASSERTIONS
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is taken");

    a_center_grad: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_center_reg) |-> (o_gx_reg == '0 && o_gy_reg == '0))
        else $error("gradient not zero at center");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_sat_reg) |-> (o_blend_reg == BLEND_MAX[ACC_W-1:0]))
        else $error("saturated blend not at maximum");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_field_reg <= FIELD_ONE))
        else $error("field above one");
`endif

endmodule

[hdl/cff_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// cff_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module cff_sqrt_cell
    import cff_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t d_in,
    output sqrt_t d_out
);

    logic [REM_W+1:0] cat;
    logic [REM_W+1:0] trial;
    sqrt_t            res_next;
    sqrt_t            res_reg;

    always_comb
    begin
        cat          = {d_in.rem, d_in.rad[RADICAND_W-1 -: 2]};
        trial        = {1'b0, d_in.root, 2'b01};
        res_next.rad = {d_in.rad[RADICAND_W-3:0], 2'b00};
        if (cat >= trial)
        begin
            res_next.rem  = REM_W'(cat - trial);
            res_next.root = {d_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res_next.rem  = REM_W'(cat);
            res_next.root = {d_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign d_out = res_reg;

endmodule

[hdl/cff_div_cell.sv]
// ----------------------------------------------------------------------------
// cff_div_cell
// One restoring division step: trial subtract, shift in a quotient bit.
// ----------------------------------------------------------------------------
module cff_div_cell
    import cff_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    div_t res_next;
    div_t res_reg;

    always_comb
    begin
        res_next.den = d_in.den >> 1;
        if (d_in.num >= d_in.den)
        begin
            res_next.num = d_in.num - d_in.den;
            res_next.q   = {d_in.q[Q_W-2:0], 1'b1};
        end
        else
        begin
            res_next.num = d_in.num;
            res_next.q   = {d_in.q[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign d_out = res_reg;

endmodule

[tb/sv/circle_falloff_field_eval_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_falloff_field_eval_tb
// Streams directed and random points under random idling on both stream
// sides and checks every result against a local predictor or a table value.
// A directed table covers coordinate and accumulator extremes, the center
// point and blend overflow. Random points then run under several register
// settings, among them the extremes and a zero falloff width.
// ----------------------------------------------------------------------------
module circle_falloff_field_eval_tb;
    import cff_pkg::*;

    typedef struct packed {
        logic [15:0] field;
        logic [17:0] blend;
        logic [15:0] gx;
        logic [15:0] gy;
        logic        ctr;
        logic        sat;
    } field_res_t;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [17:0] acc;
        bit          typed;
        field_res_t  res;
    } point_row_t;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int NPHASE = 6;
    localparam int PHASE_POINTS = 210;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          cur_cx;
    int          cur_cy;
    int unsigned cur_r1;
    int unsigned cur_r2;

    field_res_t  pending_results[$];
    int          n_errors;
    int          n_checked;
    int          idle_cycles;
    int          rx_wait;

    circle_falloff_field_eval u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] unit_grad(int delta, longint unsigned dq);
        longint unsigned mag;
        longint unsigned q;
        mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        q = ((mag << 22) + dq / 2) / dq;
        if (q > 16384)
            q = 16384;
        return (delta < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic field_res_t eval_point(logic [15:0] px, logic [15:0] py,
                                              logic [17:0] acc);
        field_res_t      r;
        int              dx;
        int              dy;
        longint unsigned sq;
        longint unsigned dq;
        longint unsigned r1e;
        longint unsigned r2e;
        longint unsigned diff;
        longint unsigned t;
        longint unsigned fld;
        longint unsigned sum;
        dx = int'($signed(px)) - cur_cx;
        dy = int'($signed(py)) - cur_cy;
        sq = longint'(dx) * dx + longint'(dy) * dy;
        dq = int_sqrt(sq << 16);
        r1e = longint'(cur_r1) << 8;
        r2e = longint'(cur_r2 == 0 ? 1 : cur_r2) << 8;
        diff = (dq >= r1e) ? dq - r1e : r1e - dq;
        t = ((diff << 14) + r2e / 2) / r2e;
        if (dq >= r1e)
            fld = (t >= 16384) ? 0 : 16384 - t;
        else
            fld = (16384 + t > 32768) ? 32768 : 16384 + t;
        sum = acc + fld;
        r.sat = sum > 262143;
        if (r.sat)
            sum = 262143;
        r.field = 16'(fld);
        r.blend = 18'(sum);
        r.ctr = dq == 0;
        r.gx = r.ctr ? 16'd0 : unit_grad(dx, dq);
        r.gy = r.ctr ? 16'd0 : unit_grad(dy, dq);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want,
                 n_checked);
        n_errors++;
    endtask

    // receiver: random stalls with stretches of full rate
    always @(posedge clk)
    begin
        field_res_t got;
        field_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[33:16], m_axis_tdata[49:34],
                   m_axis_tdata[65:50], m_axis_tdata[66], m_axis_tdata[67]};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result transaction", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.field !== want.field)
                    report_mismatch("field_value", got.field, want.field);
                if (got.blend !== want.blend)
                    report_mismatch("blended_field", got.blend, want.blend);
                if (got.gx !== want.gx)
                    report_mismatch("grad_x", $signed(got.gx), $signed(want.gx));
                if (got.gy !== want.gy)
                    report_mismatch("grad_y", $signed(got.gy), $signed(want.gy));
                if (got.ctr !== want.ctr)
                    report_mismatch("at_center", got.ctr, want.ctr);
                if (got.sat !== want.sat)
                    report_mismatch("blend_saturated", got.sat, want.sat);
            end
            n_checked++;
            rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if ((n_checked / 100) % 4 == 1)
                rx_wait = 0;
        end
        if (rx_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_CENTER_X:      cur_cx = int'($signed(value));
            REG_CENTER_Y:      cur_cy = int'($signed(value));
            REG_INNER_RADIUS:  cur_r1 = value[14:0];
            REG_FALLOFF_WIDTH: cur_r2 = value[14:0];
            default: ;
        endcase
    endtask

    task automatic load_circle(int cx, int cy, int r1, int r2);
        wait_drained();
        write_reg(REG_CENTER_X, 16'(cx));
        write_reg(REG_CENTER_Y, 16'(cy));
        write_reg(REG_INNER_RADIUS, 16'(r1));
        write_reg(REG_FALLOFF_WIDTH, 16'(r2));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_point(logic [15:0] px, logic [15:0] py, logic [17:0] acc,
                              bit typed, field_res_t res, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, acc, py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(typed ? res : eval_point(px, py, acc));
    endtask

    function automatic logic [15:0] near_coord(int c, int span);
        return 16'(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    initial
    begin
        point_row_t  rows[$];
        point_row_t  row;
        field_res_t  none;
        int          ph_cx[NPHASE];
        int          ph_cy[NPHASE];
        int          ph_r1[NPHASE];
        int          ph_r2[NPHASE];
        logic [15:0] px;
        logic [15:0] py;
        logic [17:0] acc;
        int          span;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        cur_cx = 0;
        cur_cy = 0;
        cur_r1 = 0;
        cur_r2 = 16;
        n_errors = 0;
        n_checked = 0;
        idle_cycles = 0;
        rx_wait = 0;
        none = '0;

        rows.push_back('{16'd0, 16'd0, 18'd0, 1'b1, '{16'd16384, 18'd16384, 16'd0,
                          16'd0, 1'b1, 1'b0}});
        rows.push_back('{16'd0, 16'd0, 18'h3FFFF, 1'b1, '{16'd16384, 18'h3FFFF,
                          16'd0, 16'd0, 1'b1, 1'b1}});
        rows.push_back('{16'h7FFF, 16'h7FFF, 18'h3FFFF, 1'b0, none});
        rows.push_back('{16'h8000, 16'h8000, 18'd0, 1'b0, none});
        rows.push_back('{16'h7FFF, 16'h8000, 18'h2AAAA, 1'b0, none});
        rows.push_back('{16'h8000, 16'h7FFF, 18'h15555, 1'b0, none});
        rows.push_back('{16'd16, 16'd0, 18'd0, 1'b0, none});
        rows.push_back('{16'd0, 16'hFFF0, 18'd0, 1'b0, none});
        rows.push_back('{16'd8, 16'd8, 18'h3C000, 1'b0, none});
        rows.push_back('{16'd1, 16'd0, 18'h3FFFE, 1'b0, none});
        rows.push_back('{16'hFFFF, 16'hFFFF, 18'd1, 1'b0, none});
        rows.push_back('{16'h5555, 16'hAAAA, 18'h1FFFF, 1'b0, none});

        ph_cx = '{0, -32768, 32767, 0, 120, -400};
        ph_cy = '{0, 32767, -32768, 0, -64, 900};
        ph_r1 = '{0, 32767, 0, 0, 800, 32767};
        ph_r2 = '{16, 1, 32767, 0, 200, 32767};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_point(row.px, row.py, row.acc, row.typed, row.res, 1'b0);
        end

        for (int p = 0; p < NPHASE; p++)
        begin
            if (p > 0)
            begin
                load_circle(ph_cx[p], ph_cy[p], ph_r1[p], ph_r2[p]);
                send_point(16'(ph_cx[p]), 16'(ph_cy[p]), 18'h3FFFF, 1'b0, none,
                           1'b0);
            end
            span = ph_r1[p] + 2 * (ph_r2[p] == 0 ? 1 : ph_r2[p]) + 8;
            if (span > 32768)
                span = 32768;
            for (int k = 0; k < PHASE_POINTS; k++)
            begin
                case ($urandom_range(0, 3))
                    0: begin
                        px = 16'($urandom);
                        py = 16'($urandom);
                    end
                    1: begin
                        px = near_coord(ph_cx[p], 4);
                        py = near_coord(ph_cy[p], 4);
                    end
                    default: begin
                        px = near_coord(ph_cx[p], span);
                        py = near_coord(ph_cy[p], span);
                    end
                endcase
                case ($urandom_range(0, 2))
                    0: acc = 18'($urandom);
                    1: acc = 18'(262143 - $urandom_range(0, 40000));
                    default: acc = 18'($urandom_range(0, 255));
                endcase
                if (k == PHASE_POINTS / 2)
                    wait_drained();
                send_point(px, py, acc, 1'b0, none, (k / 32) % 3 == 2);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results across %0d circle settings, incl. extremes",
                 n_checked, NPHASE);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[circle_falloff_field_eval.f]
hdl/cff_pkg.sv
hdl/cff_sqrt_cell.sv
hdl/cff_div_cell.sv
hdl/circle_falloff_field_eval.sv
tb/sv/circle_falloff_field_eval_tb.sv
